// ----- rtl/lmc_pkg.sv -----
// Shared types, constants and coefficient helpers for the Laws mask convolution.
// Used by lmc_mask_mac, laws_mask_convolution and lmc_checker; no dependencies.
package lmc_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned Win        = 5;
  localparam int unsigned RowSlots   = MaxWidth + 4;
  localparam int unsigned AddrW      = $clog2(RowSlots);
  localparam int unsigned ColW       = 11;
  localparam int unsigned FifoDepth  = 8;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned RespMax    = 65280;

  // Register byte addresses on the config port
  localparam logic [2:0] RegImageWidth = 3'd0;
  localparam logic [2:0] RegMaskIndex  = 3'd4;
  localparam logic [10:0] WidthReset   = 11'd640;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic signed [16:0] response;
    logic               end_of_row;
  } result_t;

  typedef logic [Win-1:0][Win-1:0][7:0] win_t;   // [row][col], col 4 newest
  typedef logic signed [3:0] coef_t;

  // Control traveling alongside a window into the MAC
  typedef struct packed {
    logic valid;
    logic row_end;
  } mac_ctrl_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] vert;
    logic [2:0] horz;
  } mask_sel_t;

  // L5, E5, S5, W5, R5
  localparam coef_t LawsVec [Win][Win] = '{
    '{ 4'sd1,  4'sd4, 4'sd6,  4'sd4,  4'sd1},
    '{-4'sd1, -4'sd2, 4'sd0,  4'sd2,  4'sd1},
    '{-4'sd1,  4'sd0, 4'sd2,  4'sd0, -4'sd1},
    '{-4'sd1,  4'sd2, 4'sd0, -4'sd2,  4'sd1},
    '{ 4'sd1, -4'sd4, 4'sd6, -4'sd4,  4'sd1}
  };

  // Split mask index into vertical and horizontal vector numbers
  function automatic mask_sel_t mask_decode(logic [4:0] idx);
    mask_sel_t  sel;
    logic [2:0] a;
    logic [4:0] rem;
    if      (idx >= 5'd20) a = 3'd4;
    else if (idx >= 5'd15) a = 3'd3;
    else if (idx >= 5'd10) a = 3'd2;
    else if (idx >= 5'd5)  a = 3'd1;
    else                   a = 3'd0;
    rem = idx - 5'(a * 3'd5);
    sel.valid = (idx <= 5'd24);
    sel.vert  = sel.valid ? a : 3'd0;
    sel.horz  = sel.valid ? rem[2:0] : 3'd0;
    return sel;
  endfunction

endpackage

// ----- rtl/lmc_mask_mac.sv -----
// Two-stage separable multiply-accumulate: column sums, then row sum of a 5x5 window.
// Depends on lmc_pkg for the window type, coefficients and control struct.
module lmc_mask_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          mask_index_i,
  input  lmc_pkg::win_t       window_i,
  input  lmc_pkg::mac_ctrl_t  ctrl_i,
  output lmc_pkg::mac_ctrl_t  ctrl_o,
  output logic signed [16:0]  response_o,
  output logic [1:0]          pending_o
);

  lmc_pkg::mask_sel_t sel;
  lmc_pkg::coef_t     coef_v [lmc_pkg::Win];
  lmc_pkg::coef_t     coef_h [lmc_pkg::Win];

  logic signed [13:0] vsum_d [lmc_pkg::Win];
  logic signed [13:0] vsum_q [lmc_pkg::Win];
  logic signed [19:0] acc_d;
  logic signed [16:0] resp_q;
  lmc_pkg::mac_ctrl_t ctrl_a_q, ctrl_b_q;

  assign sel = lmc_pkg::mask_decode(mask_index_i);

  always_comb begin
    for (int i = 0; i < lmc_pkg::Win; i++) begin
      coef_v[i] = sel.valid ? lmc_pkg::LawsVec[sel.vert][i] : 4'sd0;
      coef_h[i] = sel.valid ? lmc_pkg::LawsVec[sel.horz][i] : 4'sd0;
    end
  end

  // Vertical pass: one sum per window column
  always_comb begin
    logic signed [8:0]  px;
    logic signed [12:0] prod;
    for (int c = 0; c < lmc_pkg::Win; c++) begin
      vsum_d[c] = '0;
      for (int r = 0; r < lmc_pkg::Win; r++) begin
        px   = signed'({1'b0, window_i[r][c]});
        prod = coef_v[r] * px;
        vsum_d[c] = vsum_d[c] + 14'(prod);
      end
    end
  end

  // Horizontal pass over the registered column sums
  always_comb begin
    logic signed [17:0] prod;
    acc_d = '0;
    for (int c = 0; c < lmc_pkg::Win; c++) begin
      prod  = coef_h[c] * vsum_q[c];
      acc_d = acc_d + 20'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_b_q <= '0;
    end else begin
      ctrl_a_q <= ctrl_i;
      ctrl_b_q <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < lmc_pkg::Win; c++) vsum_q[c] <= vsum_d[c];
    resp_q <= acc_d[16:0];
  end

  assign ctrl_o     = ctrl_b_q;
  assign response_o = resp_q;
  assign pending_o  = {1'b0, ctrl_a_q.valid} + {1'b0, ctrl_b_q.valid};

endmodule

// ----- rtl/laws_mask_convolution.sv -----
// Top level of the Laws 5x5 texture mask convolution over a zero-padded pixel stream.
// Depends on lmc_pkg and lmc_mask_mac; holds the line store, window and result queue.
//
//   channel | direction | handshake                      | payload
//   --------+-----------+--------------------------------+---------------------------
//   in      | request   | in_valid_i / in_stall_o        | in_data_i  (pixel_in_t)
//   out     | result    | out_valid_o / out_stall_i      | out_data_o (result_t)
//   config  | APB       | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One pixel per clock is accepted back to back while in_stall_o is low. A pixel
// reaches the result queue through line store read, window shift and write-back,
// column sums, row sum and queue write. The line store is a single-port-write,
// single-read memory of one 32-bit word per padded column, read-modified-written
// once per pixel. Reset is asynchronous and clears control state and the window;
// the line store is not cleared. A stalled output fills the eight-entry queue, and
// in_stall_o rises once queued plus in-flight results reach its depth.
module laws_mask_convolution (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lmc_pkg::pixel_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lmc_pkg::result_t      out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] image_width_q;
  logic [4:0]  mask_index_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // Decode on the word address only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= lmc_pkg::WidthReset;
      mask_index_q  <= '0;
    end else if (cfg_wr) begin
      unique case ({paddr[2], 2'b00})
        lmc_pkg::RegImageWidth: image_width_q <= pwdata[10:0];
        lmc_pkg::RegMaskIndex:  mask_index_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case ({paddr[2], 2'b00})
      lmc_pkg::RegImageWidth: prdata = {21'd0, image_width_q};
      lmc_pkg::RegMaskIndex:  prdata = {27'd0, mask_index_q};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept a request, position it in the padded row, issue the read
  // ---------------------------------------------------------------------------
  logic        in_acc;
  logic [10:0] width_eff;
  logic [10:0] last_col;
  logic [10:0] col_base;
  logic [10:0] col;
  logic [2:0]  row_base;
  logic        row_end;
  logic        emit;
  logic [10:0] col_count_q, col_count_d;
  logic [2:0]  row_count_q, row_count_d;

  assign in_acc = in_valid_i & ~in_stall_o;

  // Clamp width to 1..MaxWidth, then padded row holds four more
  always_comb begin
    width_eff = image_width_q;
    if (width_eff == 11'd0) width_eff = 11'd1;
    if (width_eff > 11'(lmc_pkg::MaxWidth)) width_eff = 11'(lmc_pkg::MaxWidth);
    last_col = width_eff + 11'd3;
  end

  always_comb begin
    col_base = in_data_i.frame_start ? 11'd0 : col_count_q;
    row_base = in_data_i.frame_start ? 3'd0  : row_count_q;
    col      = (col_base > last_col) ? last_col : col_base;
    row_end  = (col == last_col);
    emit     = (row_base >= 3'd4) && (col >= 11'd4);
    if (row_end) begin
      col_count_d = '0;
      row_count_d = (row_base < 3'd4) ? row_base + 3'd1 : row_base;
    end else begin
      col_count_d = col + 11'd1;
      row_count_d = row_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (in_acc) begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one word per padded column, byte r holds row r (0 oldest)
  // ---------------------------------------------------------------------------
  logic [31:0] line_mem [lmc_pkg::RowSlots];
  logic [31:0] rd_word_q;
  logic [31:0] wr_word;
  logic [31:0] cur_word;

  logic        s1_valid_q;
  logic        s1_emit_q;
  logic        s1_row_end_q;
  logic [lmc_pkg::AddrW-1:0] s1_addr_q;
  logic [7:0]  s1_pix_q;
  logic        fwd_q;
  logic [31:0] fwd_word_q;
  logic [lmc_pkg::AddrW-1:0] rd_addr;

  assign rd_addr = col[lmc_pkg::AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) rd_word_q <= line_mem[rd_addr];
    if (s1_valid_q) line_mem[s1_addr_q] <= wr_word;
  end

  // Same column back to back: the read above saw the word before write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= in_acc & s1_valid_q & (s1_addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_word_q <= wr_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_emit_q    <= 1'b0;
      s1_row_end_q <= 1'b0;
    end else begin
      s1_valid_q   <= in_acc;
      s1_emit_q    <= in_acc & emit;
      s1_row_end_q <= row_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= rd_addr;
      s1_pix_q  <= in_data_i.pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: assemble the column, shift the window, write the column back
  // ---------------------------------------------------------------------------
  lmc_pkg::win_t      window_q;
  lmc_pkg::mac_ctrl_t s2_ctrl_q;
  lmc_pkg::mac_ctrl_t mac_ctrl;
  logic signed [16:0] mac_resp;
  logic [1:0]         mac_pending;

  assign cur_word = fwd_q ? fwd_word_q : rd_word_q;
  // Advance each row up one slot, newest pixel on top
  assign wr_word  = {s1_pix_q, cur_word[31:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      s2_ctrl_q <= '0;
    end else begin
      s2_ctrl_q.valid   <= s1_emit_q;
      s2_ctrl_q.row_end <= s1_row_end_q;
      if (s1_valid_q) begin
        for (int r = 0; r < lmc_pkg::Win; r++) begin
          for (int c = 0; c < lmc_pkg::Win - 1; c++) window_q[r][c] <= window_q[r][c+1];
        end
        for (int r = 0; r < lmc_pkg::Win - 1; r++) window_q[r][lmc_pkg::Win-1] <= cur_word[8*r +: 8];
        window_q[lmc_pkg::Win-1][lmc_pkg::Win-1] <= s1_pix_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: separable mask sum
  // ---------------------------------------------------------------------------
  lmc_mask_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mask_index_i (mask_index_q),
    .window_i     (window_q),
    .ctrl_i       (s2_ctrl_q),
    .ctrl_o       (mac_ctrl),
    .response_o   (mac_resp),
    .pending_o    (mac_pending)
  );

  // ---------------------------------------------------------------------------
  // Result queue and credit-based input stall
  // ---------------------------------------------------------------------------
  lmc_pkg::result_t fifo_q [lmc_pkg::FifoDepth];
  logic [lmc_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [lmc_pkg::FifoPtrW:0]   occ_q;
  logic [lmc_pkg::FifoPtrW+1:0] committed;
  logic push, pop;

  assign push = mac_ctrl.valid;
  assign pop  = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= '{response: mac_resp, end_of_row: mac_ctrl.row_end};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      occ_q <= occ_q + {{lmc_pkg::FifoPtrW{1'b0}}, push} - {{lmc_pkg::FifoPtrW{1'b0}}, pop};
    end
  end

  // Hold off requests once every queue slot is spoken for
  always_comb begin
    committed = {1'b0, occ_q}
              + {{lmc_pkg::FifoPtrW+1{1'b0}}, s1_emit_q}
              + {{lmc_pkg::FifoPtrW+1{1'b0}}, s2_ctrl_q.valid}
              + {{lmc_pkg::FifoPtrW{1'b0}}, mac_pending};
  end

  assign in_stall_o  = (committed >= (lmc_pkg::FifoPtrW+2)'(lmc_pkg::FifoDepth));
  assign out_valid_o = (occ_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

endmodule

// ----- rtl/lmc_checker.sv -----
// Port-level checks for laws_mask_convolution, attached by bind below.
// Depends on lmc_pkg for the payload types.
module lmc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  lmc_pkg::result_t   out_data_o,
  input  logic               pready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_resp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.response >= -17'sd65280) &&
                     (out_data_o.response <= 17'sd65280)))
    else $error("response out of range");

  // An empty queue only refills from a request accepted earlier
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 5))
    else $error("result without matching request");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind laws_mask_convolution lmc_checker u_lmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for laws_mask_convolution: padded pixel frames in, mask responses out.
// Depends on lmc_pkg and the RTL top; predicts each response and checks it field by field.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LimitCycles = 600000;
  localparam int unsigned TailCycles  = 16;   // pipeline depth plus margin
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned NoCut       = 32'hFFFF_FFFF;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Pixel request channel
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  lmc_pkg::pixel_in_t in_data_i  = '0;

  // Result channel
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  lmc_pkg::result_t out_data_o;

  // Config port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  laws_mask_convolution u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the block: configuration, line store, window and counters.
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_width = lmc_pkg::WidthReset;
  logic [4:0]  cfg_mask  = '0;
  logic [7:0]  line_rows [4][lmc_pkg::RowSlots];
  bit   [7:0]  win_px    [5][5];
  int unsigned col_cnt   = 0;
  int unsigned row_cnt   = 0;

  lmc_pkg::pixel_in_t pixel_backlog [$];   // requests waiting for the driver
  lmc_pkg::result_t   resp_due      [$];   // predicted responses, oldest first

  int unsigned n_queued = 0;
  int unsigned n_taken  = 0;
  int unsigned n_err    = 0;
  int unsigned cycles   = 0;

  // Idle percentages, switched by the sequence between phases
  int unsigned send_gap_pct   = 29;
  int unsigned recv_stall_pct = 80;

  // Long receiver hold-off
  bit          hold_arm  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Padded row length for a programmed width: zero acts as one, clamp at the maximum
  function automatic int unsigned padded_cols(input logic [10:0] w);
    int unsigned eff;
    eff = w;
    if (eff < 1) eff = 1;
    if (eff > lmc_pkg::MaxWidth) eff = lmc_pkg::MaxWidth;
    return eff + 4;
  endfunction

  // Laws vectors in order L5, E5, S5, W5, R5
  function automatic int laws_tap(input int unsigned vec, input int unsigned k);
    int t [5];
    case (vec)
      0:       t = '{ 1,  4, 6,  4,  1};
      1:       t = '{-1, -2, 0,  2,  1};
      2:       t = '{-1,  0, 2,  0, -1};
      3:       t = '{-1,  2, 0, -2,  1};
      default: t = '{ 1, -4, 6, -4,  1};
    endcase
    return t[k];
  endfunction

  // Advance the shadow by one accepted pixel; queue a response once the window is full
  task automatic convolve_pixel(input lmc_pkg::pixel_in_t px);
    int unsigned      last, col;
    logic [7:0]       column [5];
    bit               row_end, emit;
    int               sum;
    lmc_pkg::result_t res;
    last = padded_cols(cfg_width) - 1;
    if (px.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    // A width shrunk mid-row ends the row at the new last column
    col = (col_cnt > last) ? last : col_cnt;
    for (int r = 0; r < 4; r++) column[r] = line_rows[r][col];
    column[4] = px.pixel;
    for (int r = 0; r < 3; r++) line_rows[r][col] = line_rows[r + 1][col];
    line_rows[3][col] = px.pixel;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) win_px[r][c] = win_px[r][c + 1];
      win_px[r][4] = column[r];
    end
    row_end = (col == last);
    emit    = (row_cnt >= 4) && (col >= 4);
    if (row_end) begin
      col_cnt = 0;
      if (row_cnt < 4) row_cnt++;
    end else begin
      col_cnt = (col + 1) & 11'h7FF;
    end
    if (emit) begin
      sum = 0;
      // Mask indexes past the last mask give an all-zero mask
      if (cfg_mask <= 5'd24)
        for (int r = 0; r < 5; r++)
          for (int c = 0; c < 5; c++)
            sum += laws_tap(cfg_mask / 5, r) * laws_tap(cfg_mask % 5, c) * int'(win_px[r][c]);
      res.response   = 17'(sum);
      res.end_of_row = row_end;
      resp_due.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold a request until accepted, then offer the next one or idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        convolve_pixel(in_data_i);
        n_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data_i  <= pixel_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted response with the oldest prediction.
  // ---------------------------------------------------------------------------
  lmc_pkg::result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (resp_due.size() == 0) begin
          $display("%0t: response with none expected: response %0d end_of_row %0b",
                   $time, $signed(out_data_o.response), out_data_o.end_of_row);
          n_err++;
        end else begin
          want = resp_due.pop_front();
          if (out_data_o.response !== want.response) begin
            $display("%0t: response mismatch: expected %0d actual %0d", $time,
                     $signed(want.response), $signed(out_data_o.response));
            n_err++;
          end
          if (out_data_o.end_of_row !== want.end_of_row) begin
            $display("%0t: end_of_row mismatch: expected %0b actual %0b", $time,
                     want.end_of_row, out_data_o.end_of_row);
            n_err++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hold-off counter: once armed, stall the result side for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("%0t: timeout, %0d responses still expected", $time, resp_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Config port access: setup then access phase, wait for pready.
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic [2:0] addr, input logic [31:0] wdata,
                            input bit is_write, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Read a register back and compare with the shadow copy
  task automatic reg_expect(input logic [2:0] addr);
    logic [31:0] got, exp_val;
    apb_access(addr, 32'd0, 1'b0, got);
    exp_val = (addr == lmc_pkg::RegMaskIndex) ? {27'd0, cfg_mask} : {21'd0, cfg_width};
    if (got !== exp_val) begin
      $display("%0t: register %0d readback: expected %0d actual %0d", $time, addr,
               exp_val, got);
      n_err++;
    end
  endtask

  // Write a register with junk in the unused upper bits, update the shadow, read back
  task automatic program_reg(input logic [2:0] addr, input int unsigned value);
    logic [31:0] wdata, unused;
    if (addr == lmc_pkg::RegMaskIndex) wdata = ($urandom() & 32'hFFFF_FFE0) | value;
    else                               wdata = ($urandom() & 32'hFFFF_F800) | value;
    apb_access(addr, wdata, 1'b1, unused);
    if (addr == lmc_pkg::RegMaskIndex) cfg_mask = wdata[4:0];
    else                               cfg_width = wdata[10:0];
    reg_expect(addr);
  endtask

  // Queue a padded frame: zero border unless noisy, cut short after 'cut' requests
  task automatic queue_frame(input logic [10:0] w_cfg, input int unsigned rows,
                             input bit noisy, input int unsigned cut, input bit restart);
    int unsigned        pw, idx, r, c;
    bit                 interior;
    lmc_pkg::pixel_in_t px;
    pw  = padded_cols(w_cfg);
    idx = 0;
    for (r = 0; r < rows + 4; r++) begin
      for (c = 0; c < pw; c++) begin
        if (idx < cut) begin
          interior       = (r >= 2) && (r < rows + 2) && (c >= 2) && (c < pw - 2);
          px.pixel       = (noisy || interior) ? 8'($urandom_range(255)) : 8'd0;
          px.frame_start = restart && (idx == 0);
          pixel_backlog.push_back(px);
          n_queued++;
        end
        idx++;
      end
    end
  endtask

  // Wait until every request is taken and every response has come, then let the
  // pipeline empty of any pixel that produced no response
  task automatic settle();
    while (n_taken != n_queued || resp_due.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      0:       begin send_gap_pct = 29; recv_stall_pct = 80; end
      1:       begin send_gap_pct = 80; recv_stall_pct = 29; end
      default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int unsigned        k, w, h, pick, base;
    lmc_pkg::pixel_in_t px;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_idle(0);

    // Reset values of both registers
    reg_expect(lmc_pkg::RegImageWidth);
    reg_expect(lmc_pkg::RegMaskIndex);

    // Directed: width 0 acts as 1, so one 5x5 frame gives a single response.
    // Saturate every pixel, border included, for the largest L5L5 response.
    program_reg(lmc_pkg::RegImageWidth, 0);
    program_reg(lmc_pkg::RegMaskIndex, 0);
    for (int i = 0; i < 25; i++) begin
      px.pixel       = 8'hFF;
      px.frame_start = (i == 0);
      pixel_backlog.push_back(px);
      n_queued++;
    end
    settle();

    // Random frames: sweep every mask index first, then pick at random
    k = 0;
    while (k < 36 || n_queued < 725) begin
      set_idle(k < 12 ? 0 : (k < 24 ? 1 : 2));
      program_reg(lmc_pkg::RegMaskIndex, k < 32 ? k : $urandom_range(31));
      pick = $urandom_range(9);
      w    = ($urandom_range(7) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
      h    = $urandom_range(3, 1);
      case (k)
        0: begin
          // Full width once: writes every line store column for later stale reads
          program_reg(lmc_pkg::RegImageWidth, lmc_pkg::MaxWidth);
          queue_frame(cfg_width, 1, 1'b0, NoCut, 1'b1);
        end
        12: begin
          // Width past the maximum clamps to it
          program_reg(lmc_pkg::RegImageWidth, 2047);
          queue_frame(cfg_width, 1, 1'b0, NoCut, 1'b1);
        end
        5, 20: begin
          // Width changed mid-frame: shrink in one case, grow in the other
          program_reg(lmc_pkg::RegImageWidth, k == 5 ? 6 : 3);
          queue_frame(cfg_width, 6, 1'b0, 5 * padded_cols(cfg_width) + 7, 1'b1);
          settle();
          program_reg(lmc_pkg::RegImageWidth, k == 5 ? 2 : 9);
          queue_frame(cfg_width, 2, 1'b1, NoCut, 1'b0);
        end
        26: begin
          // Back pressure: stall the result side long enough to fill the block
          program_reg(lmc_pkg::RegImageWidth, 24);
          base = n_queued;
          queue_frame(cfg_width, 4, 1'b0, NoCut, 1'b1);
          while (n_taken < base + 4 * padded_cols(cfg_width) + 4) @(negedge clk_i);
          hold_arm = 1'b1;
        end
        default: begin
          program_reg(lmc_pkg::RegImageWidth, w);
          if (pick == 0)      queue_frame(cfg_width, h, 1'b1, NoCut, 1'b1);
          else if (pick == 1) queue_frame(cfg_width, h + 2, 1'b0,
                                          $urandom_range(padded_cols(cfg_width) * 7, 1), 1'b1);
          else                queue_frame(cfg_width, h, 1'b0, NoCut, 1'b1);
        end
      endcase
      settle();
      k++;
    end

    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lmc_pkg.sv
rtl/lmc_mask_mac.sv
rtl/laws_mask_convolution.sv
rtl/lmc_checker.sv
tb/tb_top.sv
